// ===== design/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtp_pkg: shared types and constants of the DER TLV header parser
// Phase codes, result kinds, error codes, register indexes and the structs
// that pass between the front queue, the parser and the register block.
// ----------------------------------------------------------------------------
package dtp_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [2:0] {
    PH_IDENT   = 3'd0,
    PH_TAGNUM  = 3'd1,
    PH_LENIND  = 3'd2,
    PH_LENOCT  = 3'd3,
    PH_CONTENT = 3'd4,
    PH_SKIP    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_EOF        = 3'd1,
    ERR_NOTCANON   = 3'd2,
    ERR_TAGOVF     = 3'd3,
    ERR_INVLEN     = 3'd4,
    ERR_INDEF      = 3'd5,
    ERR_LENOVF     = 3'd6,
    ERR_UNEXPECTED = 3'd7
  } err_e;

  localparam logic [CfgIdxW-1:0] CFG_CHECK_EXPECTED       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXPECTED_CLASS       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_EXPECTED_CONSTRUCTED = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_EXPECTED_NUMBER      = 2'd3;

  // A byte as it leaves the front, with its byte-level properties decoded.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_last;
    logic       low5_ones;
    logic       low7_zero;
    logic       byte_zero;
    logic       is_ff;
    logic       is_80;
  } front_item_t;

  typedef struct packed {
    logic        check_expected;
    logic [1:0]  expected_class;
    logic        expected_constructed;
    logic [63:0] expected_number;
  } cfg_t;

endpackage

// ===== design/dtp_if.sv =====
// ----------------------------------------------------------------------------
// dtp_in_if / dtp_out_if: byte and result channels of the parser
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface dtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_last;

  modport source (output valid, output data_byte, output buffer_last, input ready);
  modport sink   (input valid, input data_byte, input buffer_last, output ready);
endinterface

interface dtp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  tag_class;
  logic        constructed;
  logic [63:0] tag_number;
  logic [63:0] content_length;
  logic [7:0]  content_byte;
  logic        element_end;
  logic [2:0]  err_code;

  modport source (output valid, output kind, output tag_class, output constructed,
                  output tag_number, output content_length, output content_byte,
                  output element_end, output err_code, input ready);
  modport sink   (input valid, input kind, input tag_class, input constructed,
                  input tag_number, input content_length, input content_byte,
                  input element_end, input err_code, output ready);
endinterface

// ===== design/dtp_front.sv =====
// ----------------------------------------------------------------------------
// dtp_front: input stage of the parser
// Accepts bytes, decodes their byte-level properties and holds them in a
// short queue so that the parser and the input side stall independently.
// ----------------------------------------------------------------------------
module dtp_front import dtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtp_in_if.sink      in_i,
  output front_item_t item_o,
  output logic        item_valid_o,
  input  logic        item_pop_i
);

  front_item_t                entry_q [QueueDepth];
  logic [QueuePtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]       count_q, count_d;
  front_item_t                cls;
  logic                       push, pop;

  always_comb begin
    cls.data_byte   = in_i.data_byte;
    cls.buffer_last = in_i.buffer_last;
    cls.low5_ones   = (in_i.data_byte[4:0] == 5'h1f);
    cls.low7_zero   = (in_i.data_byte[6:0] == 7'h00);
    cls.byte_zero   = (in_i.data_byte == 8'h00);
    cls.is_ff       = (in_i.data_byte == 8'hff);
    cls.is_80       = (in_i.data_byte == 8'h80);
  end

  assign in_i.ready   = (count_q != QueueCntW'(QueueDepth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = entry_q[rd_ptr_q];
  assign push         = in_i.valid && in_i.ready;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== design/dtp_back.sv =====
// ----------------------------------------------------------------------------
// dtp_back: TLV header state machine and result register
// Walks identifier, tag number, length and content phases, applies the DER
// checks and loads each result into an output register.
// ----------------------------------------------------------------------------
module dtp_back import dtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  front_item_t item_i,
  input  logic        item_valid_i,
  output logic        item_pop_o,
  dtp_out_if.source   out_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  held_class_q, held_class_d;
  logic        held_cons_q, held_cons_d;
  logic [63:0] number_q, number_d;
  logic        first_q, first_d;
  logic [63:0] length_q, length_d;
  logic [6:0]  oct_left_q, oct_left_d;
  logic [63:0] content_q, content_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q, kind_d;
  logic [1:0]  tag_class_q, tag_class_d;
  logic        cons_q, cons_d;
  logic [63:0] tag_number_q, tag_number_d;
  logic [63:0] clen_q, clen_d;
  logic [7:0]  cbyte_q, cbyte_d;
  logic        end_q, end_d;
  logic [2:0]  ecode_q, ecode_d;

  logic        pop, last, err, fin, res;
  err_e        code;
  logic [63:0] fin_len, num_shift, len_shift;
  logic [7:0]  b;
  logic        mismatch;

  assign pop        = item_valid_i && (!out_valid_q || out_o.ready);
  assign item_pop_o = pop;
  assign b          = item_i.data_byte;
  assign last       = item_i.buffer_last;
  assign num_shift  = {number_q[56:0], b[6:0]};
  assign len_shift  = {length_q[55:0], b};
  assign mismatch   = cfg_i.check_expected &&
                      ((held_class_q != cfg_i.expected_class) ||
                       (held_cons_q != cfg_i.expected_constructed) ||
                       (number_q != cfg_i.expected_number));

  always_comb begin
    phase_d      = phase_q;
    held_class_d = held_class_q;
    held_cons_d  = held_cons_q;
    number_d     = number_q;
    first_d      = first_q;
    length_d     = length_q;
    oct_left_d   = oct_left_q;
    content_d    = content_q;
    err          = 1'b0;
    code         = ERR_NONE;
    fin          = 1'b0;
    fin_len      = '0;
    res          = 1'b0;
    kind_d       = kind_q;
    tag_class_d  = '0;
    cons_d       = 1'b0;
    tag_number_d = '0;
    clen_d       = '0;
    cbyte_d      = '0;
    end_d        = 1'b0;
    ecode_d      = ERR_NONE;

    unique case (phase_q)
      PH_TAGNUM: begin
        if (first_q && item_i.low7_zero) begin
          err = 1'b1; code = ERR_NOTCANON;
        end else begin
          first_d  = 1'b0;
          number_d = num_shift;
          if (b[7]) begin
            // Another octet follows; the value must leave room for seven more bits.
            if (|num_shift[63:57]) begin
              err = 1'b1; code = ERR_TAGOVF;
            end else if (last) begin
              err = 1'b1; code = ERR_EOF;
            end
          end else if (num_shift < 64'h1f) begin
            err = 1'b1; code = ERR_NOTCANON;
          end else if (last) begin
            err = 1'b1; code = ERR_EOF;
          end else begin
            phase_d = PH_LENIND;
          end
        end
      end
      PH_LENIND: begin
        if (item_i.is_ff) begin
          err = 1'b1; code = ERR_INVLEN;
        end else if (item_i.is_80) begin
          err = 1'b1; code = ERR_INDEF;
        end else if (b[7]) begin
          length_d = '0;
          if (last) begin
            err = 1'b1; code = ERR_EOF;
          end else begin
            oct_left_d = b[6:0];
            phase_d    = PH_LENOCT;
          end
        end else begin
          length_d = {56'd0, b};
          fin      = 1'b1;
          fin_len  = {56'd0, b};
        end
      end
      PH_LENOCT: begin
        if ((length_q == '0) && item_i.byte_zero) begin
          err = 1'b1; code = ERR_NOTCANON;
        end else if (|length_q[63:56]) begin
          err = 1'b1; code = ERR_LENOVF;
        end else begin
          length_d   = len_shift;
          oct_left_d = oct_left_q - 1'b1;
          if (oct_left_d != '0) begin
            if (last) begin
              err = 1'b1; code = ERR_EOF;
            end
          end else if (len_shift[63:7] == '0) begin
            err = 1'b1; code = ERR_NOTCANON;
          end else begin
            fin     = 1'b1;
            fin_len = len_shift;
          end
        end
      end
      PH_CONTENT: begin
        if ((content_q > 64'd1) && last) begin
          err = 1'b1; code = ERR_EOF;
        end else begin
          res       = 1'b1;
          kind_d    = KIND_CONTENT;
          cbyte_d   = b;
          content_d = content_q - 1'b1;
          if (content_d == '0) begin
            end_d   = 1'b1;
            phase_d = PH_IDENT;
          end
        end
      end
      PH_SKIP: begin
        if (last) begin
          phase_d = PH_IDENT;
        end
      end
      default: begin
        held_class_d = b[7:6];
        held_cons_d  = b[5];
        first_d      = 1'b1;
        length_d     = '0;
        oct_left_d   = '0;
        content_d    = '0;
        number_d     = item_i.low5_ones ? 64'd0 : {59'd0, b[4:0]};
        if (last) begin
          err = 1'b1; code = ERR_EOF;
        end else begin
          phase_d = item_i.low5_ones ? PH_TAGNUM : PH_LENIND;
        end
      end
    endcase

    // A complete header: truncation wins over a tag mismatch.
    if (fin) begin
      if ((fin_len != '0) && last) begin
        err = 1'b1; code = ERR_EOF;
      end else if (mismatch) begin
        err = 1'b1; code = ERR_UNEXPECTED;
      end else begin
        res          = 1'b1;
        kind_d       = KIND_HEADER;
        tag_class_d  = held_class_q;
        cons_d       = held_cons_q;
        tag_number_d = number_q;
        clen_d       = fin_len;
        end_d        = (fin_len == '0);
        content_d    = fin_len;
        phase_d      = (fin_len == '0) ? PH_IDENT : PH_CONTENT;
      end
    end

    if (err) begin
      res          = 1'b1;
      kind_d       = KIND_ERROR;
      tag_class_d  = '0;
      cons_d       = 1'b0;
      tag_number_d = '0;
      clen_d       = '0;
      cbyte_d      = '0;
      end_d        = 1'b0;
      ecode_d      = code;
      phase_d      = last ? PH_IDENT : PH_SKIP;
    end

    out_valid_d = out_valid_q && !out_o.ready;
    if (pop && res) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDENT;
      held_class_q <= '0;
      held_cons_q  <= 1'b0;
      number_q     <= '0;
      first_q      <= 1'b1;
      length_q     <= '0;
      oct_left_q   <= '0;
      content_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        phase_q      <= phase_d;
        held_class_q <= held_class_d;
        held_cons_q  <= held_cons_d;
        number_q     <= number_d;
        first_q      <= first_d;
        length_q     <= length_d;
        oct_left_q   <= oct_left_d;
        content_q    <= content_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && res) begin
      kind_q       <= kind_d;
      tag_class_q  <= tag_class_d;
      cons_q       <= cons_d;
      tag_number_q <= tag_number_d;
      clen_q       <= clen_d;
      cbyte_q      <= cbyte_d;
      end_q        <= end_d;
      ecode_q      <= ecode_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = kind_q;
  assign out_o.tag_class      = tag_class_q;
  assign out_o.constructed    = cons_q;
  assign out_o.tag_number     = tag_number_q;
  assign out_o.content_length = clen_q;
  assign out_o.content_byte   = cbyte_q;
  assign out_o.element_end    = end_q;
  assign out_o.err_code       = ecode_q;

endmodule

// ===== design/der_tlv_header_parser.sv =====
// Each byte is queued in the front; its result, if any, is then registered.
// Throughput: one byte per cycle; the parser state machine takes one queued byte
// per cycle whenever the result register is free or being drained.
// Reset empties the queue and clears the parser state, the output valid and the
// expected-tag registers; the empty queue lets the block accept bytes out of reset.
// ----------------------------------------------------------------------------
// der_tlv_header_parser: streaming DER TLV header parser
// Front queue, header state machine and the expected-tag register block.
// ----------------------------------------------------------------------------
module der_tlv_header_parser import dtp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  dtp_in_if.sink              in_i,
  dtp_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t        cfg_q;
  front_item_t item;
  logic        item_valid, item_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHECK_EXPECTED:       cfg_q.check_expected       <= cfg_wdata_i[0];
        CFG_EXPECTED_CLASS:       cfg_q.expected_class       <= cfg_wdata_i[1:0];
        CFG_EXPECTED_CONSTRUCTED: cfg_q.expected_constructed <= cfg_wdata_i[0];
        CFG_EXPECTED_NUMBER:      cfg_q.expected_number      <= cfg_wdata_i[63:0];
        default: ;
      endcase
    end
  end

  dtp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  dtp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .out_o        (out_o)
  );

endmodule
